// ===== rtl/core/pli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_pkg
// Shared widths, codes and the division stage record for the interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = 6;
    localparam int CNT_W      = 7;
    localparam int DATA_W     = 32;
    localparam int DIFF_W     = 33;
    localparam int PROD_W     = 66;
    localparam int QCAP_W     = 41;
    localparam int SUM_W      = 43;
    localparam int PADDR_W    = 3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic REG_EXTRAP = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [DIFF_W-1:0] den;
        logic [DIFF_W-1:0] rem;
        logic [PROD_W-1:0] word;
    } pli_div_stage_t;

endpackage

// ===== rtl/core/pli_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_if
// Request and response channels of the interpolator.
// ----------------------------------------------------------------------------
interface pli_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [5:0]  point_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;

    modport source (output valid, command, point_index, x_value, y_value, input ready);
    modport sink   (input valid, command, point_index, x_value, y_value, output ready);
endinterface

interface pli_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] y_result;
    logic        error;

    modport source (output valid, y_result, error, input ready);
    modport sink   (input valid, y_result, error, output ready);
endinterface

// ===== rtl/core/pli_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_div_cell
// One restoring division step; registered hand-off to the next cell.
// ----------------------------------------------------------------------------
module pli_div_cell
    import pli_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  pli_div_stage_t stage_in,
    output pli_div_stage_t stage_out
);

    logic [DIFF_W:0]   trial;
    logic              take;
    logic [DIFF_W:0]   diff;
    logic              valid_reg;
    logic [DIFF_W-1:0] den_reg;
    logic [DIFF_W-1:0] rem_reg;
    logic [PROD_W-1:0] word_reg;

    always_comb
    begin
        trial = {stage_in.rem, stage_in.word[PROD_W-1]};
        take  = (trial >= {1'b0, stage_in.den});
        diff  = trial - {1'b0, stage_in.den};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg  <= stage_in.den;
        rem_reg  <= take ? diff[DIFF_W-1:0] : trial[DIFF_W-1:0];
        word_reg <= {stage_in.word[PROD_W-2:0], take};
    end

    always_comb
    begin
        stage_out.valid = valid_reg;
        stage_out.den   = den_reg;
        stage_out.rem   = rem_reg;
        stage_out.word  = word_reg;
    end

endmodule

// ===== rtl/core/pli_div_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_div_chain
// Row of division cells, one quotient bit per cell.
// ----------------------------------------------------------------------------
module pli_div_chain
    import pli_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  pli_div_stage_t div_in,
    output pli_div_stage_t div_out
);

    pli_div_stage_t stage [0:PROD_W];

    assign stage[0] = div_in;

    for (genvar i = 0; i < PROD_W; i++)
    begin : g_cell
        pli_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (stage[i]),
            .stage_out (stage[i+1])
        );
    end

    assign div_out = stage[PROD_W];

endmodule

// ===== rtl/core/piecewise_linear_interpolator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_core
// Knot table, binary search and interpolation with saturated Q16.16 result.
//
//   channel  dir  beat
//   req      in   command, point_index, x_value, y_value
//   rsp      out  y_result, error
//   apb      in   allow_extrapolation (0x0), point_count (0x4)
//
// Load beat: written into the table when taken. Evaluate beat: its length
// is set by the search steps on the single table read port and by the
// 66-cell division chain; an empty table skips both. One item in flight at a
// time; a finished beat waits in the output register while the next
// request is taken. No clearing pass after reset.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_core
    import pli_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    pli_req_if.sink            req,
    pli_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD0  = 4'd1;
    localparam logic [3:0] S_RD1  = 4'd2;
    localparam logic [3:0] S_SRCH = 4'd3;
    localparam logic [3:0] S_CMP  = 4'd4;
    localparam logic [3:0] S_FLI  = 4'd5;
    localparam logic [3:0] S_FL   = 4'd6;
    localparam logic [3:0] S_LO   = 4'd7;
    localparam logic [3:0] S_UP   = 4'd8;
    localparam logic [3:0] S_MUL0 = 4'd9;
    localparam logic [3:0] S_MUL1 = 4'd10;
    localparam logic [3:0] S_MUL2 = 4'd11;
    localparam logic [3:0] S_DIV  = 4'd12;
    localparam logic [3:0] S_ADD  = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_POINTS);
    localparam logic [QCAP_W-1:0] QCAP     = {1'b1, {(QCAP_W-1){1'b0}}};
    localparam int                LO_W     = 17;
    localparam int                HI_W     = DIFF_W - LO_W;

    logic [DATA_W-1:0] x_mem [0:MAX_POINTS-1];
    logic [DATA_W-1:0] y_mem [0:MAX_POINTS-1];
    logic signed [DATA_W-1:0] x_rd_reg, y_rd_reg;
    logic [ADDR_W-1:0] rd_addr;

    logic [3:0]               state_reg, state_next;
    logic                     ext_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic signed [DATA_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]         above_reg, above_next, below_reg, below_next;
    logic [CNT_W-1:0]         mid_reg, mid_next;
    logic [ADDR_W-1:0]        low_reg, low_next;
    logic signed [DATA_W-1:0] x0_reg, x0_next, y0_reg, y0_next;
    logic signed [DATA_W-1:0] xl_reg, xl_next, yl_reg, yl_next, yu_reg, yu_next;
    logic [DIFF_W-1:0]        ma_reg, ma_next, mb_reg, mb_next, den_reg, den_next;
    logic                     neg_reg, neg_next;
    logic [LO_W+DIFF_W-1:0]   part_reg, part_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [QCAP_W-1:0]        m_reg, m_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic                     err_reg, err_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    logic signed [DATA_W-1:0] rsp_y_reg, rsp_y_next;
    logic                     rsp_err_reg, rsp_err_next;

    logic                     req_fire, cfg_wr;
    logic [CNT_W-1:0]         n_eff;
    logic [CNT_W:0]           mid_sum;
    logic signed [DIFF_W-1:0] dx, dy, dd;
    logic [HI_W+DIFF_W-1:0]   part_hi;
    logic [PROD_W-1:0]        quo;
    logic signed [SUM_W-1:0]  sum;
    pli_div_stage_t           div_in, div_out;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_COUNT) ? {{(32-CNT_W){1'b0}}, cnt_reg}
                                                : {31'b0, ext_reg};
    assign n_eff     = (cnt_reg > MAX_CNT) ? MAX_CNT : cnt_reg;

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.y_result = rsp_y_reg;
    assign rsp.error    = rsp_err_reg;

    always_ff @(posedge clk)
    begin
        if (req_fire && req.command == CMD_LOAD)
        begin
            x_mem[req.point_index] <= req.x_value;
            y_mem[req.point_index] <= req.y_value;
        end
        x_rd_reg <= x_mem[rd_addr];
        y_rd_reg <= y_mem[rd_addr];
    end

    pli_div_chain u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_in  (div_in),
        .div_out (div_out)
    );

    always_comb
    begin
        div_in.valid = (state_reg == S_MUL2);
        div_in.den   = den_reg;
        div_in.rem   = '0;
        div_in.word  = prod_reg;
    end

    always_comb
    begin
        mid_sum = {1'b0, above_reg} + {1'b0, below_reg};
        dx      = {q_reg[DATA_W-1], q_reg} - {y_rd_reg[DATA_W-1] ^ y_rd_reg[DATA_W-1],
                                                 1'b0, {(DATA_W-1){1'b0}}}
                  - {x_rd_reg[DATA_W-1], x_rd_reg};
        dy      = {yl_reg[DATA_W-1], yl_reg} - {y_rd_reg[DATA_W-1], y_rd_reg};
        dd      = {xl_reg[DATA_W-1], xl_reg} - {x_rd_reg[DATA_W-1], x_rd_reg};
        part_hi = ma_reg * mb_reg[DIFF_W-1:LO_W];
        quo     = div_out.word;
        sum     = neg_reg ? ({{(SUM_W-DATA_W){yu_reg[DATA_W-1]}}, yu_reg}
                             - SUM_W'(m_reg))
                          : ({{(SUM_W-DATA_W){yu_reg[DATA_W-1]}}, yu_reg}
                             + SUM_W'(m_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        q_next     = q_reg;
        above_next = above_reg;
        below_next = below_reg;
        mid_next   = mid_reg;
        low_next   = low_reg;
        x0_next    = x0_reg;
        y0_next    = y0_reg;
        xl_next    = xl_reg;
        yl_next    = yl_reg;
        yu_next    = yu_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        part_next  = part_reg;
        prod_next  = prod_reg;
        m_next     = m_reg;
        res_next   = res_reg;
        err_next   = err_reg;
        rd_addr    = '0;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_y_next     = rsp_y_reg;
        rsp_err_next   = rsp_err_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire && req.command == CMD_EVAL)
                begin
                    q_next   = req.x_value;
                    n_next   = n_eff;
                    err_next = 1'b0;
                    if (n_eff == '0)
                    begin
                        res_next   = '0;
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RD0;
                    end
                end
            end
            S_RD0:
            begin
                x0_next    = x_rd_reg;
                y0_next    = y_rd_reg;
                rd_addr    = ADDR_W'(n_reg - 1'b1);
                state_next = S_RD1;
            end
            S_RD1:
            begin
                if (n_reg == CNT_W'(1))
                begin
                    res_next   = y0_reg;
                    state_next = S_DONE;
                end
                else if (!ext_reg && q_reg <= x0_reg)
                begin
                    res_next   = y0_reg;
                    state_next = S_DONE;
                end
                else if (!ext_reg && q_reg >= x_rd_reg)
                begin
                    res_next   = y_rd_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    above_next = n_reg + 1'b1;
                    below_next = '0;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (above_reg - below_reg > CNT_W'(1))
                begin
                    mid_next   = mid_sum[CNT_W:1];
                    rd_addr    = ADDR_W'(mid_sum[CNT_W:1] - 1'b1);
                    state_next = S_CMP;
                end
                else
                begin
                    low_next   = (below_reg == '0) ? '0 : ADDR_W'(below_reg - 1'b1);
                    state_next = S_FLI;
                end
            end
            S_CMP:
            begin
                if (q_reg == x_rd_reg)
                begin
                    low_next   = ADDR_W'(mid_reg - 1'b1);
                    state_next = S_FLI;
                end
                else
                begin
                    if (q_reg < x_rd_reg)
                    begin
                        above_next = mid_reg;
                    end
                    else
                    begin
                        below_next = mid_reg;
                    end
                    state_next = S_SRCH;
                end
            end
            S_FLI:
            begin
                rd_addr    = low_reg;
                state_next = S_FL;
            end
            S_FL:
            begin
                if (x_rd_reg == q_reg)
                begin
                    res_next   = y_rd_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    if ({1'b0, low_reg} == n_reg - 1'b1)
                    begin
                        low_next = low_reg - 1'b1;
                        rd_addr  = low_reg - 1'b1;
                    end
                    else
                    begin
                        rd_addr = low_reg;
                    end
                    state_next = S_LO;
                end
            end
            S_LO:
            begin
                xl_next    = x_rd_reg;
                yl_next    = y_rd_reg;
                rd_addr    = low_reg + 1'b1;
                state_next = S_UP;
            end
            S_UP:
            begin
                yu_next = y_rd_reg;
                if (xl_reg == x_rd_reg)
                begin
                    res_next   = yl_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    ma_next    = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
                    mb_next    = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
                    den_next   = dd[DIFF_W-1] ? DIFF_W'(-dd) : DIFF_W'(dd);
                    neg_next   = dx[DIFF_W-1] ^ dy[DIFF_W-1] ^ dd[DIFF_W-1];
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                part_next  = ma_reg * mb_reg[LO_W-1:0];
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                prod_next  = PROD_W'(part_reg) + {part_hi, {LO_W{1'b0}}};
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_out.valid)
                begin
                    if ((|quo[PROD_W-1:QCAP_W]) || (quo[QCAP_W-1:0] > QCAP))
                    begin
                        m_next = QCAP;
                    end
                    else
                    begin
                        m_next = quo[QCAP_W-1:0];
                    end
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                if (!(&sum[SUM_W-1:DATA_W-1]) && (|sum[SUM_W-1:DATA_W-1]))
                begin
                    res_next = sum[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                            : {1'b0, {(DATA_W-1){1'b1}}};
                end
                else
                begin
                    res_next = sum[DATA_W-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_y_next     = res_reg;
                    rsp_err_next   = err_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            ext_reg       <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr && paddr[2] == REG_EXTRAP)
            begin
                ext_reg <= pwdata[0];
            end
            if (cfg_wr && paddr[2] == REG_COUNT)
            begin
                cnt_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        q_reg     <= q_next;
        above_reg <= above_next;
        below_reg <= below_next;
        mid_reg   <= mid_next;
        low_reg   <= low_next;
        x0_reg    <= x0_next;
        y0_reg    <= y0_next;
        xl_reg    <= xl_next;
        yl_reg    <= yl_next;
        yu_reg    <= yu_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
        part_reg  <= part_next;
        prod_reg  <= prod_next;
        m_reg     <= m_next;
        res_reg   <= res_next;
        err_reg   <= err_next;
        rsp_y_reg <= rsp_y_next;
        rsp_err_reg <= rsp_err_next;
    end

    a_div_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_out.valid |-> state_reg == S_DIV)
        else $error("division result outside wait state");

    a_error_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.error |-> rsp.y_result == '0)
        else $error("error beat with nonzero value");

    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> (mid_reg > below_reg) && (mid_reg < above_reg))
        else $error("search midpoint outside bounds");

endmodule
